FILE: hw/rtl/ecvm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Euler camera view matrix package
// Shared types and fixed-point constants for the camera view matrix block.
// ---------------------------------------------------------------------------
package ecvm_pkg;

  // Binary angle conversion factor from Q8.8 degrees.
  localparam logic [15:0] DEG_TO_ANGLE = 16'd46603;

  // Taylor coefficients of sin(pi/2 * w), Q30.
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  localparam logic signed [17:0] Q16_ONE = 18'sd65536;

  // Register indexes.
  localparam logic REG_PITCH_LO = 1'b0;
  localparam logic REG_PITCH_HI = 1'b1;

  // Request and response between sequencer and the sine unit.
  typedef struct packed {
    logic        start;
    logic [31:0] angle;  // angle left-aligned to 32 bits
  } sin_req_t;

  typedef struct packed {
    logic               done;
    logic signed [17:0] value;
  } sin_rsp_t;

endpackage

FILE: hw/rtl/euler_camera_view_matrix_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Euler camera view matrix
// Accumulates pitch, yaw and roll, forms R = Rz*Ry*Rx in Q1.16 and emits the
// rigid inverse view transform: R transposed and -R^T * p.
// ---------------------------------------------------------------------------
// Usage: an update transfer on the input channel (in_valid/in_ready) carries
// angle increments in Q8.8 degrees and a new camera position. After the
// update, one result transfer on the output channel (out_valid/out_ready)
// delivers nine Q1.16 matrix terms and a Q16.8 translation.
// The steps are: degree conversion of each increment, the angle update,
// six sines on the sine unit's shared Horner multiplier, then eighteen
// matrix terms and three translation terms, each summed from three products
// by multiply-accumulate on one shared multiplier, and loading the result.
// One item is processed at a time; in_ready is high only when the block is
// idle with no result pending, so a new update is not taken until the
// previous result has been taken by the receiver.
// A stalled receiver holds the result; the block then waits.
// Reset zeroes the angles and the position and restores the pitch limits.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the user must make them only while the block is idle (not enforced).
// ---------------------------------------------------------------------------
module euler_camera_view_matrix_top #(
  parameter int ANGLE_BITS = 24,
  parameter int POS_BITS   = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [23:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         delta_pitch,
  input  logic signed [15:0]         delta_yaw,
  input  logic signed [15:0]         delta_roll,
  input  logic signed [POS_BITS-1:0] pos_x,
  input  logic signed [POS_BITS-1:0] pos_y,
  input  logic signed [POS_BITS-1:0] pos_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [17:0]         m00,
  output logic signed [17:0]         m01,
  output logic signed [17:0]         m02,
  output logic signed [17:0]         m10,
  output logic signed [17:0]         m11,
  output logic signed [17:0]         m12,
  output logic signed [17:0]         m20,
  output logic signed [17:0]         m21,
  output logic signed [17:0]         m22,
  output logic signed [POS_BITS:0]   tx,
  output logic signed [POS_BITS:0]   ty,
  output logic signed [POS_BITS:0]   tz
);

  // Pitch holds the 24-bit limits as well as full-width angles.
  localparam int PBW = (ANGLE_BITS > 24) ? ANGLE_BITS : 24;
  localparam int PW  = PBW + 2;  // pitch sum width
  // Second multiplier operand carries a position or a Q1.16 term.
  localparam int OBW = (POS_BITS > 18) ? POS_BITS : 18;
  // Accumulator holds three Q1.16 by Q1.16 products or a translation sum.
  localparam int AW  = (POS_BITS + 21 > 40) ? POS_BITS + 21 : 40;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEL  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_SIN  = 7'b0001000,
    S_MAT  = 7'b0010000,
    S_TRN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } st_t;

  st_t st;

  logic signed [23:0]         lo_lim;
  logic [22:0]                hi_lim;
  logic signed [PBW-1:0]      pitch;
  logic [ANGLE_BITS-1:0]      yaw;
  logic [ANGLE_BITS-1:0]      roll;
  logic signed [POS_BITS-1:0] pos [3];
  logic signed [15:0]         dl [3];
  logic signed [ANGLE_BITS:0] dang [3];
  logic [1:0]                 ai;     // delta index
  logic [2:0]                 si;     // sine index
  logic                       sin_busy;
  logic                       sin_start;
  logic signed [17:0]         sc [6]; // sx cx sy cy sz cz
  logic signed [17:0]         a [9];  // Rz*Ry
  logic signed [17:0]         r [9];  // final R, row major
  logic [1:0]                 kk;
  logic signed [AW-1:0]       acc;

  ecvm_pkg::sin_req_t sreq;
  ecvm_pkg::sin_rsp_t srsp;

  ecvm_sin u_sin (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  // Shared 16x16 degree conversion.
  logic signed [32:0] dprod;
  logic signed [24:0] d24;
  assign dprod = dl[ai] * $signed({1'b0, ecvm_pkg::DEG_TO_ANGLE});
  assign d24   = 25'(dprod >>> 8);

  // Sine source angle, left-aligned to 32 bits.
  logic [ANGLE_BITS-1:0] src;
  logic [31:0]           src32;
  always_comb begin
    case (si[2:1])
      2'd0:    src = ANGLE_BITS'(pitch);
      2'd1:    src = yaw;
      default: src = roll;
    endcase
    if (si[0]) src = src + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
    src32 = 32'({src, 32'd0} >> ANGLE_BITS);
  end

  // Matrix element lookup for the shared multiplier.
  logic signed [17:0] sx, cx, sy, cy, sz, cz;
  assign sx = sc[0]; assign cx = sc[1]; assign sy = sc[2];
  assign cy = sc[3]; assign sz = sc[4]; assign cz = sc[5];

  function automatic logic signed [17:0] rz_e(input logic [3:0] idx,
      input logic signed [17:0] s, input logic signed [17:0] c);
    case (idx)
      4'd0: rz_e = c; 4'd1: rz_e = -s; 4'd3: rz_e = s; 4'd4: rz_e = c;
      4'd8: rz_e = ecvm_pkg::Q16_ONE;
      default: rz_e = 18'sd0;
    endcase
  endfunction
  function automatic logic signed [17:0] ry_e(input logic [3:0] idx,
      input logic signed [17:0] s, input logic signed [17:0] c);
    case (idx)
      4'd0: ry_e = c; 4'd2: ry_e = s; 4'd6: ry_e = -s; 4'd8: ry_e = c;
      4'd4: ry_e = ecvm_pkg::Q16_ONE;
      default: ry_e = 18'sd0;
    endcase
  endfunction
  function automatic logic signed [17:0] rx_e(input logic [3:0] idx,
      input logic signed [17:0] s, input logic signed [17:0] c);
    case (idx)
      4'd4: rx_e = c; 4'd5: rx_e = -s; 4'd7: rx_e = s; 4'd8: rx_e = c;
      4'd0: rx_e = ecvm_pkg::Q16_ONE;
      default: rx_e = 18'sd0;
    endcase
  endfunction

  // Element (i,j) with term k: i = elem/3, j = elem%3 via counter tables.
  logic [3:0] elem;
  logic [1:0] ci, cj;
  logic       pass2;
  always_comb begin
    case (elem)
      4'd0, 4'd1, 4'd2: ci = 2'd0;
      4'd3, 4'd4, 4'd5: ci = 2'd1;
      default:          ci = 2'd2;
    endcase
    cj = 2'(elem - {ci, 1'b0} - {2'd0, ci});
  end

  logic signed [17:0]    op_a;
  logic signed [OBW-1:0] op_b;
  always_comb begin
    op_a = 18'sd0;
    op_b = '0;
    if (st == S_MAT) begin
      if (!pass2) begin
        op_a = rz_e(4'({ci, 1'b0} + ci + kk), sz, cz);
        op_b = OBW'(ry_e(4'({kk, 1'b0} + kk + cj), sy, cy));
      end else begin
        op_a = a[4'({ci, 1'b0} + ci + kk)];
        op_b = OBW'(rx_e(4'({kk, 1'b0} + kk + cj), sx, cx));
      end
    end else begin
      // Translation row i uses R[k][i] * p_k.
      op_a = r[4'({kk, 1'b0} + kk + ci)];
      op_b = OBW'(pos[kk]);
    end
  end

  logic signed [OBW+17:0] mprod;
  assign mprod = op_a * op_b;

  logic signed [AW-1:0] acc_n;
  logic signed [AW-1:0] rnd;
  assign acc_n = acc + AW'(mprod);
  assign rnd   = (acc_n + AW'(32768)) >>> 16;

  // Pitch sum and clamp.
  logic signed [PW-1:0] psum;
  assign psum = PW'(pitch) + PW'(dang[0]);

  assign in_ready = (st == S_IDLE) && !out_valid;
  assign sreq = '{start: sin_start, angle: src32};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
      lo_lim <= -24'sd4194180;
      hi_lim <= 23'd4193513;
      pitch <= '0; yaw <= '0; roll <= '0;
      for (int i = 0; i < 3; i++) pos[i] <= '0;
      sin_start <= 1'b0;
      sin_busy <= 1'b0;
    end else begin
      // In the sine state, a sine request is issued whenever the sine unit is free.
      sin_start <= (st == S_SIN) && !sin_busy;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == ecvm_pkg::REG_PITCH_LO) lo_lim <= $signed(cfg_data);
        else hi_lim <= cfg_data[22:0];
      end
      case (st)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dl[0] <= delta_pitch; dl[1] <= delta_yaw; dl[2] <= delta_roll;
            pos[0] <= pos_x; pos[1] <= pos_y; pos[2] <= pos_z;
            ai <= 2'd0;
            st <= S_DEL;
          end
        end
        S_DEL: begin
          // Scale the 24-bit binary angle to ANGLE_BITS.
          if (ANGLE_BITS >= 24)
            dang[ai] <= (ANGLE_BITS+1)'(d24) <<< (ANGLE_BITS >= 24 ? ANGLE_BITS - 24 : 0);
          else
            dang[ai] <= (ANGLE_BITS+1)'(d24 >>> (ANGLE_BITS < 24 ? 24 - ANGLE_BITS : 0));
          if (ai == 2'd2) st <= S_ACC;
          ai <= ai + 2'd1;
        end
        S_ACC: begin
          if (psum > $signed(PW'(hi_lim)) ? ($signed(PW'(hi_lim)) < PW'(lo_lim))
                                          : (psum < PW'(lo_lim)))
            pitch <= PBW'(lo_lim);
          else if (psum > $signed(PW'(hi_lim))) pitch <= PBW'(hi_lim);
          else pitch <= PBW'(psum);
          yaw  <= yaw + ANGLE_BITS'(dang[1]);
          roll <= roll + ANGLE_BITS'(dang[2]);
          si <= 3'd0;
          st <= S_SIN;
        end
        S_SIN: begin
          if (!sin_busy) begin
            sin_busy <= 1'b1;
          end else if (srsp.done) begin
            sc[si] <= srsp.value;
            sin_busy <= 1'b0;
            si <= si + 3'd1;
            if (si == 3'd5) begin
              st <= S_MAT; elem <= 4'd0; kk <= 2'd0; pass2 <= 1'b0;
              acc <= '0;
            end
          end
        end
        S_MAT: begin
          if (kk == 2'd2) begin
            if (!pass2) a[elem] <= 18'(rnd);
            else begin
              if (rnd > 65536) r[elem] <= ecvm_pkg::Q16_ONE;
              else if (rnd < -65536) r[elem] <= -ecvm_pkg::Q16_ONE;
              else r[elem] <= 18'(rnd);
            end
            acc <= '0; kk <= 2'd0;
            if (elem == 4'd8) begin
              elem <= 4'd0;
              if (pass2) st <= S_TRN;
              pass2 <= 1'b1;
            end else elem <= elem + 4'd1;
          end else begin
            acc <= acc_n; kk <= kk + 2'd1;
          end
        end
        S_TRN: begin
          if (kk == 2'd2) begin
            logic signed [AW-1:0] t;
            t = -rnd;
            if (t > $signed(AW'((64'd1 << POS_BITS) - 1)))
              t = AW'((64'd1 << POS_BITS) - 1);
            else if (t < -$signed(AW'(64'd1 << POS_BITS)))
              t = -$signed(AW'(64'd1 << POS_BITS));
            case (ci)
              2'd0:    tx <= (POS_BITS+1)'(t);
              2'd1:    ty <= (POS_BITS+1)'(t);
              default: tz <= (POS_BITS+1)'(t);
            endcase
            acc <= '0; kk <= 2'd0;
            if (elem == 4'd6) st <= S_OUT;
            elem <= elem + 4'd3;
          end else begin
            acc <= acc_n; kk <= kk + 2'd1;
          end
        end
        S_OUT: begin
          m00 <= r[0]; m01 <= r[3]; m02 <= r[6];
          m10 <= r[1]; m11 <= r[4]; m12 <= r[7];
          m20 <= r[2]; m21 <= r[5]; m22 <= r[8];
          out_valid <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ecvm_sin.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sine unit
// Iterative Horner evaluation of a fixed-point sine with one shared multiplier.
// ---------------------------------------------------------------------------
module ecvm_sin (
  input  logic              clk,
  input  logic              rst,
  input  ecvm_pkg::sin_req_t req,
  output ecvm_pkg::sin_rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_HORN = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } st_t;

  st_t         st;
  logic [1:0]  quad;
  logic [30:0] w;
  logic [30:0] w2;
  logic [31:0] p;
  logic [2:0]  step;

  logic [29:0] z;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [33:0] shifted;
  logic [31:0] coef;
  logic [17:0] mag;

  assign z = req.angle[29:0];

  // The single shared multiplier.
  always_comb begin
    mul_a = {1'b0, w};
    mul_b = {1'b0, w};
    if (st == S_HORN) begin
      mul_a = {1'b0, w2};
      mul_b = p;
    end else if (st == S_FIN) begin
      mul_b = p;
    end
  end
  assign prod    = mul_a * mul_b;
  assign shifted = prod[63:30];

  always_comb begin
    case (step)
      3'd0:    coef = ecvm_pkg::SIN_C7;
      3'd1:    coef = ecvm_pkg::SIN_C5;
      3'd2:    coef = ecvm_pkg::SIN_C3;
      default: coef = ecvm_pkg::SIN_C1;
    endcase
  end

  // Round Q30 to Q16 and limit to one.
  always_comb begin
    logic [33:0] r;
    r = (shifted + 34'd8192) >> 14;
    mag = (r > 34'd65536) ? 18'd65536 : r[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (st == S_FIN);
      case (st)
        S_IDLE: begin
          if (req.start) begin
            quad <= req.angle[31:30];
            w    <= req.angle[30] ? (31'h40000000 - {1'b0, z}) : {1'b0, z};
            st   <= S_SQ;
          end
        end
        S_SQ: begin
          w2   <= shifted[30:0];
          p    <= ecvm_pkg::SIN_C9;
          step <= 3'd0;
          st   <= S_HORN;
        end
        S_HORN: begin
          p    <= coef - shifted[31:0];
          step <= step + 3'd1;
          if (step == 3'd3) st <= S_FIN;
        end
        S_FIN: begin
          rsp.value <= quad[1] ? -$signed(mag) : $signed(mag);
          st        <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
